[design/rcdt_gaussian_base_sampler_core_macros.svh]
// Assertion helpers for the base sampler core.
`ifndef RCDT_GAUSSIAN_BASE_SAMPLER_CORE_MACROS_SVH
`define RCDT_GAUSSIAN_BASE_SAMPLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RCDT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcdt core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RCDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcdt core: next-cycle check failed");

`endif

[design/rcdt_pkg.sv]
`timescale 1ns / 1ps
package rcdt_pkg;

    localparam int unsigned MAX_ROWS      = 64;
    localparam int unsigned LIMB_W        = 32;
    localparam int unsigned ROW_W         = 3 * LIMB_W;
    localparam int unsigned IDX_W         = 6;
    localparam int unsigned MAG_W         = 7;
    localparam int unsigned ADDR_W        = $clog2(MAX_ROWS);
    localparam int unsigned CNT_W         = $clog2(MAX_ROWS + 1);
    localparam int unsigned IN_DATA_W     = 200;
    localparam int unsigned OUT_DATA_W    = 8;

    localparam logic [MAG_W-1:0] ENTRIES_RESET = MAG_W'(36);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef logic [LIMB_W-1:0] t_limb;

    typedef struct packed {
        t_limb high;
        t_limb mid;
        t_limb low;
    } t_row;

endpackage

[design/rcdt_gaussian_base_sampler_core.sv]
// Reverse-CDT Gaussian base sampler.
// Input stream (s_axis): tuser selects the item kind. A load transfer writes
// one 96-bit table row (index and three limbs in tdata) and gives no result.
// A sample transfer brings a 96-bit draw; tlast marks the end of a batch and
// returns on m_axis_tlast with the result.
// Output stream (m_axis): tdata holds the magnitude, the count of in-use rows
// that exceed the draw.
// Config: i_cfg_we writes the number of rows scanned per sample (saturates at
// the table depth); write it only while the core is idle.
// A sample walks the table one row per cycle through a single 96-bit compare
// unit fed by the registered read port of the row RAM. After the scan the
// core posts the result and goes back to idle, and only then takes the next
// transfer.
// s_axis_tready is low from the scan until the result is posted. The result
// sits in an output register; a new item is accepted while it waits, but a
// finished scan holds until the register is free. Reset empties the output
// and sets the row count to 36; table contents are undefined until loaded.
`timescale 1ns / 1ps
`include "rcdt_gaussian_base_sampler_core_macros.svh"
module rcdt_gaussian_base_sampler_core
    import rcdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // row_index[5:0], row_low, row_mid, row_high, draw_low, draw_mid,
    // draw_high, zero pad[199:198]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // magnitude[6:0], zero pad[7]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [MAG_W-1:0]      i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [MAG_W-1:0] r_entries;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_rd_vld, n_rd_vld;
    t_row             r_draw, n_draw;
    logic             r_last, n_last;
    logic             r_out_vld, n_out_vld;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic             r_out_last, n_out_last;

    logic [IDX_W-1:0] w_row_index;
    t_row             w_row_in;
    t_row             w_draw_in;
    t_row             w_ram_rdata;
    logic             w_accept;
    logic             w_load_we;
    logic             w_issue;
    logic             w_hit;
    logic [CNT_W-1:0] w_n_sat;

    assign w_row_index = s_axis_tdata[IDX_W-1:0];
    assign w_row_in    = {s_axis_tdata[IDX_W+3*LIMB_W-1:IDX_W+2*LIMB_W],
                          s_axis_tdata[IDX_W+2*LIMB_W-1:IDX_W+LIMB_W],
                          s_axis_tdata[IDX_W+LIMB_W-1:IDX_W]};
    assign w_draw_in   = {s_axis_tdata[IDX_W+6*LIMB_W-1:IDX_W+5*LIMB_W],
                          s_axis_tdata[IDX_W+5*LIMB_W-1:IDX_W+4*LIMB_W],
                          s_axis_tdata[IDX_W+4*LIMB_W-1:IDX_W+3*LIMB_W]};

    assign s_axis_tready = r_state == ST_IDLE;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load_we     = w_accept && (s_axis_tuser == FUNC_LOAD)
                           && (32'(w_row_index) < 32'(MAX_ROWS));
    assign w_issue       = (r_state == ST_SCAN) && (r_addr < r_n);
    assign w_n_sat       = (32'(r_entries) > 32'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                            : CNT_W'(r_entries);

    rcdt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (ADDR_W'(w_row_index)),
        .i_wdata (w_row_in),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    rcdt_row_cmp u_cmp (
        .i_draw    (r_draw),
        .i_row     (w_ram_rdata),
        .o_exceeds (w_hit)
    );

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_n        = r_n;
        n_count    = r_count;
        n_rd_vld   = 1'b0;
        n_draw     = r_draw;
        n_last     = r_last;
        n_out_vld  = r_out_vld;
        n_mag      = r_mag;
        n_out_last = r_out_last;

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept && (s_axis_tuser == FUNC_SAMPLE)) begin
                    n_draw  = w_draw_in;
                    n_last  = s_axis_tlast;
                    n_n     = w_n_sat;
                    n_addr  = '0;
                    n_count = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && w_hit) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (w_issue) begin
                    n_addr   = r_addr + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_mag      = MAG_W'(r_count);
                    n_out_last = r_last;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_entries <= ENTRIES_RESET;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_n        <= n_n;
        r_count    <= n_count;
        r_draw     <= n_draw;
        r_last     <= n_last;
        r_mag      <= n_mag;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_DATA_W'(r_mag);
    assign m_axis_tlast  = r_out_last;

    `RCDT_ASSERT_NOW(a_rd_only_in_scan, r_rd_vld, r_state == ST_SCAN)
    `RCDT_ASSERT_NEXT(a_sample_starts_scan,
        w_accept && (s_axis_tuser == FUNC_SAMPLE),
        (r_state == ST_SCAN) && (r_count == '0) && (r_addr == '0))
    `RCDT_ASSERT_NOW(a_count_bounded, r_state == ST_SCAN, r_count <= r_addr)
    `RCDT_ASSERT_NOW(a_fin_full_scan, r_state == ST_FIN, r_addr == r_n)

endmodule

[design/rcdt_ram.sv]
`timescale 1ns / 1ps
module rcdt_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/rcdt_row_cmp.sv]
`timescale 1ns / 1ps
module rcdt_row_cmp
    import rcdt_pkg::*;
(
    input  t_row i_draw,
    input  t_row i_row,
    output logic o_exceeds
);

    logic  w_b0;
    logic  w_b1;
    t_limb w_mid_sum;
    t_limb w_high_sum;

    // borrow-fold chain, limb sums wrap at 32 bits
    always_comb begin
        w_b0       = i_draw.low < i_row.low;
        w_mid_sum  = i_row.mid + LIMB_W'(w_b0);
        w_b1       = i_draw.mid < w_mid_sum;
        w_high_sum = i_row.high + LIMB_W'(w_b1);
        o_exceeds  = i_draw.high < w_high_sum;
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
    import rcdt_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned SETTLE_TICKS = 100;

    typedef struct {
        logic [MAG_W-1:0] magnitude;
        logic             last_of_batch;
    } t_sample_result;

    class magnitude_scoreboard;
        t_row           table_rows [MAX_ROWS];
        int unsigned    rows_in_use;
        t_sample_result pending_samples [$];
        int unsigned    errors;

        function new();
            rows_in_use = ENTRIES_RESET;
            errors = 0;
        endfunction

        function void set_rows(logic [MAG_W-1:0] value);
            rows_in_use = value;
        endfunction

        // count scanned rows whose value exceeds the draw, via the borrow-fold chain
        function logic [MAG_W-1:0] rows_above(t_row draw);
            int unsigned scan_len;
            int unsigned hits;
            logic        borrow;
            t_limb       limb_sum;
            scan_len = (rows_in_use > MAX_ROWS) ? MAX_ROWS : rows_in_use;
            hits = 0;
            for (int unsigned i = 0; i < scan_len; i++) begin
                borrow = draw.low < table_rows[i].low;
                limb_sum = table_rows[i].mid + t_limb'(borrow);
                borrow = draw.mid < limb_sum;
                limb_sum = table_rows[i].high + t_limb'(borrow);
                borrow = draw.high < limb_sum;
                hits += borrow;
            end
            return MAG_W'(hits);
        endfunction

        function void note_transfer(logic func, logic [IN_DATA_W-1:0] data, logic last);
            logic [IDX_W-1:0] idx;
            t_row             row;
            t_row             draw;
            t_sample_result   res;
            idx       = data[IDX_W-1:0];
            row.low   = data[IDX_W +: LIMB_W];
            row.mid   = data[IDX_W + LIMB_W +: LIMB_W];
            row.high  = data[IDX_W + 2*LIMB_W +: LIMB_W];
            draw.low  = data[IDX_W + 3*LIMB_W +: LIMB_W];
            draw.mid  = data[IDX_W + 4*LIMB_W +: LIMB_W];
            draw.high = data[IDX_W + 5*LIMB_W +: LIMB_W];
            if (func == FUNC_LOAD) begin
                table_rows[idx] = row;
            end else begin
                res.magnitude = rows_above(draw);
                res.last_of_batch = last;
                pending_samples.push_back(res);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
            t_sample_result want;
            if (pending_samples.size() == 0) begin
                $error("unexpected result: magnitude %0d, last_of_batch %0b",
                       data[MAG_W-1:0], last);
                errors++;
                return;
            end
            want = pending_samples.pop_front();
            if (data[MAG_W-1:0] !== want.magnitude) begin
                $error("magnitude: expected %0d, actual %0d", want.magnitude, data[MAG_W-1:0]);
                errors++;
            end
            if (last !== want.last_of_batch) begin
                $error("last_of_batch: expected %0b, actual %0b", want.last_of_batch, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = FUNC_LOAD;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [MAG_W-1:0]      i_cfg_wdata = '0;

    magnitude_scoreboard sb = new();
    bit          send_idle = 1'b1;
    bit          recv_idle = 1'b1;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    rcdt_gaussian_base_sampler_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!recv_idle) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 8);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.set_rows(i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_transfer(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (i_cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_limb rand_limb();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'hFFFF_FFFE;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_row rand_row();
        return {rand_limb(), rand_limb(), rand_limb()};
    endfunction

    function automatic t_limb nudge(t_limb v);
        case ($urandom_range(0, 3))
            0: return v;
            1: return v - 1;
            2: return v + 1;
            default: return $urandom;
        endcase
    endfunction

    // draw close to one in-use row (any table row when none is in use) so the limb compares tie and carry
    function automatic t_row near_draw();
        int unsigned span;
        t_row        r;
        span = (sb.rows_in_use == 0 || sb.rows_in_use > MAX_ROWS) ? MAX_ROWS : sb.rows_in_use;
        r = sb.table_rows[$urandom_range(0, span - 1)];
        r.low = nudge(r.low);
        r.mid = nudge(r.mid);
        r.high = nudge(r.high);
        return r;
    endfunction

    task automatic send_item(logic func, logic [IDX_W-1:0] idx, t_row row, t_row draw,
                             logic last);
        if (send_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tlast <= last;
        s_axis_tdata <= {2'b00, draw.high, draw.mid, draw.low, row.high, row.mid, row.low, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_sample(t_row draw, logic last);
        send_item(FUNC_SAMPLE, IDX_W'($urandom), rand_row(), draw, last);
    endtask

    // let the monitor note the last transfer before waiting on the results
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
    endtask

    // change the row count only with the core idle
    task automatic write_rows(logic [MAG_W-1:0] value);
        drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [MAG_W-1:0] phase_rows [8];
        t_row             draw;

        phase_rows = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd36,
                       MAG_W'($urandom_range(2, 126)), MAG_W'($urandom_range(2, 126)), 7'd64};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole table before any scan
        for (int i = 0; i < MAX_ROWS; i++)
            send_item(FUNC_LOAD, IDX_W'(i), rand_row(), rand_row(), 1'($urandom));
        for (int i = 0; i < 3; i++)
            send_sample(near_draw(), 1'(i == 2));

        write_rows(7'd4);
        send_item(FUNC_LOAD, 6'd0, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '1, 1'b1);
        send_item(FUNC_LOAD, 6'd1, {32'h8000_0000, 32'hFFFF_FFFF, 32'd5}, rand_row(), 1'b0);
        send_item(FUNC_LOAD, 6'd2, '0, '1, 1'b1);
        send_item(FUNC_LOAD, 6'd3, {32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9}, '0, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        send_sample({32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9}, 1'b0);
        send_sample({32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA8}, 1'b0);
        send_sample({32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBAA}, 1'b1);
        send_sample({32'h8000_0000, 32'hFFFF_FFFF, 32'd4}, 1'b0);
        send_sample({32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0);
        send_sample({32'h1234_5678, 32'h9ABC_DEF1, 32'h0000_0000}, 1'b1);
        write_rows(7'd0);
        send_sample(rand_row(), 1'b1);
        write_rows(7'd1);
        send_sample('0, 1'b0);
        write_rows(7'd64);
        send_sample(near_draw(), 1'b0);
        send_sample('0, 1'b1);
        write_rows(7'd127);
        send_sample(near_draw(), 1'b0);
        send_sample('1, 1'b1);

        for (int p = 0; p < 8; p++) begin
            write_rows(phase_rows[p]);
            if (p == 7) begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end
            for (int k = 0; k < 56; k++) begin
                if (p == 5 && k == 28)
                    drain();
                if ($urandom_range(0, 3) == 0) begin
                    send_item(FUNC_LOAD, IDX_W'($urandom), rand_row(), rand_row(),
                              1'($urandom));
                end else begin
                    draw = ($urandom_range(0, 2) != 0) ? near_draw() : rand_row();
                    send_sample(draw, $urandom_range(0, 3) == 0);
                end
            end
        end

        drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_samples.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
